### hdl/abd_pkg.sv
`timescale 1ns / 1ps

package abd_pkg;

  // Bus cycle kinds carried by one input item.
  typedef enum logic [1:0] {
    OP_FETCH = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_TICK  = 2'd3
  } abd_op_t;

  typedef struct packed {
    abd_op_t     opcode;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  rom_data;
    logic [6:0]  buttons;
  } abd_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_request;
    logic       flip_screen;
    logic       palette_bank_out;
    logic       colortable_bank_out;
    logic       gfx_bank_out;
  } abd_out_t;

  typedef struct packed {
    logic irq_en;
    logic pal_sel;
    logic flip;
    logic ctab_sel;
    logic gfx_sel;
  } abd_latch_t;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_DIP_BANK_ZERO   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DIP_BANK_ONE    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEMO_SOUNDS_OFF = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEMO_OFF_BITS   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEMO_ON_BITS    = 3'd4;

  // Address map.
  localparam int unsigned RAM_OFF_W = 15;
  localparam logic [15:0] RAM_BASE   = 16'h8000;
  localparam logic [15:0] RAM_LAST   = 16'h8FFF;
  localparam logic [15:0] LATCH_BASE = 16'h9040;
  localparam logic [15:0] LATCH_LAST = 16'h9047;
  localparam logic [15:0] PORT_DIP1  = 16'h9000;
  localparam logic [15:0] PORT_DIP0  = 16'h9040;
  localparam logic [15:0] PORT_IN1   = 16'h9080;
  localparam logic [15:0] PORT_IN0   = 16'h90C0;

  // Latch select, low three address bits of the latch window.
  localparam logic [2:0] LATCH_IRQ_EN     = 3'd0;
  localparam logic [2:0] LATCH_PALETTE    = 3'd2;
  localparam logic [2:0] LATCH_FLIP       = 3'd3;
  localparam logic [2:0] LATCH_COLORTABLE = 3'd6;
  localparam logic [2:0] LATCH_GFX        = 3'd7;

  // Button bit positions.
  localparam int unsigned BTN_UP    = 0;
  localparam int unsigned BTN_DOWN  = 1;
  localparam int unsigned BTN_LEFT  = 2;
  localparam int unsigned BTN_RIGHT = 3;
  localparam int unsigned BTN_FIRE  = 4;
  localparam int unsigned BTN_START = 5;
  localparam int unsigned BTN_COIN  = 6;

  localparam logic [1:0] COIN_PULSE_LEN = 2'd2;

endpackage

### hdl/arcade_bus_decoder_io.sv
`timescale 1ns / 1ps

// Address decoder and I/O block for a Z80 style arcade board.
// Each transfer on the input channel is one bus access (opcode fetch, read,
// write) or one frame tick. An item is taken on a rising edge where start is
// high and busy is low; busy stays low, so an item can enter on every cycle.
// Each item gives exactly one result, shown for a single cycle on out_item
// while out_strobe is high. The result register and out_strobe are loaded
// together at the end of stage C, which follows stages A and B. The reciprocal
// product for the modulo by RAM_DEPTH is formed as the item is taken, the next
// cycle finishes the RAM index and performs the work RAM access with its
// registered read data, and the cycle after that decodes, updates the latches
// and the coin pulse state and loads the result register. Throughput is one
// item per cycle.
// The receiver has no way to stall the result channel; it must take every
// strobed result. Configuration writes use cfg_valid and cfg_ready, which is
// always high, and are to be made only while no item is in flight.
// A synchronous reset clears the pipeline, the latches, the coin state and
// the configuration registers; work RAM contents are left as they are.
// Sound and sprite coordinate registers have no read path on this bus, so
// writes to those windows are absorbed without effect on any result.
module arcade_bus_decoder_io #(
  parameter int RAM_DEPTH = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  abd_pkg::abd_in_t                    in_item,
  output logic                                out_strobe,
  output abd_pkg::abd_out_t                   out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [abd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [7:0]                          cfg_data
);

  import abd_pkg::*;

  // RAM index is (address - 0x8000) mod RAM_DEPTH on a 15-bit offset. The
  // quotient estimate from a floor reciprocal is at most one short, so one
  // compare and subtract finishes the remainder.
  localparam int unsigned RECIP  = (1 << RAM_OFF_W) / RAM_DEPTH;
  localparam int unsigned MUL_W  = $clog2(RECIP + 1);
  localparam int unsigned PROD_W = RAM_OFF_W + MUL_W;
  localparam int unsigned IDX_W  = $clog2(RAM_DEPTH);
  localparam logic [PROD_W-1:0]    RECIP_V   = PROD_W'(RECIP);
  localparam logic [PROD_W-1:0]    DEPTH_V   = PROD_W'(RAM_DEPTH);
  localparam logic [RAM_OFF_W:0]   DEPTH_REM = (RAM_OFF_W + 1)'(RAM_DEPTH);

  logic                   in_accept;

  // Stage A: captured item and reciprocal product.
  logic                   a_valid_r;
  abd_in_t                a_item_r;
  logic [PROD_W-1:0]      a_prod_r;

  // Stage B: RAM index and access.
  logic [MUL_W-1:0]       b_quo;
  logic [PROD_W-1:0]      b_qd;
  logic [RAM_OFF_W:0]     b_rem;
  logic [RAM_OFF_W:0]     b_rem_fix;
  logic [IDX_W-1:0]       b_idx;
  logic                   b_ram_wr;

  logic [7:0]             work_ram [RAM_DEPTH];

  // Stage C: decode and state update.
  logic                   c_valid_r;
  abd_in_t                c_item_r;
  logic [7:0]             ram_q_r;

  // Architectural state.
  abd_latch_t             latch_r, latch_nxt;
  logic [1:0]             coin_cnt_r, coin_cnt_nxt;
  logic                   coin_held_r, coin_held_nxt;

  // Configuration registers.
  logic [7:0]             dip_bank_zero_r;
  logic [7:0]             dip_bank_one_r;
  logic                   demo_sounds_off_r;
  logic [7:0]             demo_off_bits_r;
  logic [7:0]             demo_on_bits_r;

  // Result register.
  logic                   out_strobe_r;
  abd_out_t               out_item_r;
  logic [7:0]             rd_nxt;
  logic                   irq_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_accept = start && !busy;

  // Configuration write port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dip_bank_zero_r   <= '0;
      dip_bank_one_r    <= '0;
      demo_sounds_off_r <= 1'b0;
      demo_off_bits_r   <= '0;
      demo_on_bits_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DIP_BANK_ZERO:   dip_bank_zero_r   <= cfg_data;
        CFG_DIP_BANK_ONE:    dip_bank_one_r    <= cfg_data;
        CFG_DEMO_SOUNDS_OFF: demo_sounds_off_r <= cfg_data[0];
        CFG_DEMO_OFF_BITS:   demo_off_bits_r   <= cfg_data;
        CFG_DEMO_ON_BITS:    demo_on_bits_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage A. The offset from 0x8000 modulo 2^15 is just the low 15 bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_item_r <= in_item;
      a_prod_r <= PROD_W'(in_item.address[RAM_OFF_W-1:0]) * RECIP_V;
    end
  end

  // Stage B: finish the remainder and access the work RAM.
  always_comb begin
    b_quo     = a_prod_r[PROD_W-1:RAM_OFF_W];
    b_qd      = PROD_W'(b_quo) * DEPTH_V;
    b_rem     = {1'b0, a_item_r.address[RAM_OFF_W-1:0]} - b_qd[RAM_OFF_W:0];
    b_rem_fix = (b_rem >= DEPTH_REM) ? (b_rem - DEPTH_REM) : b_rem;
    b_idx     = b_rem_fix[IDX_W-1:0];
    b_ram_wr  = a_valid_r && (a_item_r.opcode == OP_WRITE) &&
                (a_item_r.address >= RAM_BASE) && (a_item_r.address <= RAM_LAST);
  end

  always_ff @(posedge clk) begin
    if (b_ram_wr) begin
      work_ram[b_idx] <= a_item_r.write_data;
    end
    if (a_valid_r) begin
      ram_q_r  <= work_ram[b_idx];
      c_item_r <= a_item_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else begin
      c_valid_r <= a_valid_r;
    end
  end

  // Stage C: read mux, I/O ports, latch writes and coin pulse.
  always_comb begin
    rd_nxt        = 8'hFF;
    irq_nxt       = 1'b0;
    latch_nxt     = latch_r;
    coin_cnt_nxt  = coin_cnt_r;
    coin_held_nxt = coin_held_r;
    if (c_valid_r) begin
      unique case (c_item_r.opcode)
        OP_FETCH: begin
          // Fetches in the upper half all wrap into work RAM.
          rd_nxt = c_item_r.address[15] ? ram_q_r : c_item_r.rom_data;
        end
        OP_READ: begin
          priority if (!c_item_r.address[15]) begin
            rd_nxt = c_item_r.rom_data;
          end else if (c_item_r.address <= RAM_LAST) begin
            rd_nxt = ram_q_r;
          end else begin
            unique case (c_item_r.address)
              PORT_DIP1: rd_nxt = dip_bank_one_r;
              PORT_DIP0: rd_nxt = dip_bank_zero_r |
                                  (demo_sounds_off_r ? demo_off_bits_r : demo_on_bits_r);
              PORT_IN1: begin
                rd_nxt[5] = !c_item_r.buttons[BTN_START];
              end
              PORT_IN0: begin
                rd_nxt[0] = !c_item_r.buttons[BTN_UP];
                rd_nxt[1] = !c_item_r.buttons[BTN_DOWN];
                rd_nxt[2] = !c_item_r.buttons[BTN_LEFT];
                rd_nxt[3] = !c_item_r.buttons[BTN_RIGHT];
                rd_nxt[7] = !c_item_r.buttons[BTN_FIRE];
                // A new coin press starts the pulse; it rearms only after
                // the coin is seen released with the pulse finished.
                if (c_item_r.buttons[BTN_COIN] && !coin_held_r) begin
                  coin_cnt_nxt  = COIN_PULSE_LEN;
                  coin_held_nxt = 1'b1;
                end
                if (coin_cnt_nxt != 2'd0) begin
                  rd_nxt[4] = 1'b0;
                end else if (!c_item_r.buttons[BTN_COIN]) begin
                  coin_held_nxt = 1'b0;
                end
              end
              default: rd_nxt = 8'hFF;
            endcase
          end
        end
        OP_WRITE: begin
          if ((c_item_r.address >= LATCH_BASE) && (c_item_r.address <= LATCH_LAST)) begin
            unique case (c_item_r.address[2:0])
              LATCH_IRQ_EN:     latch_nxt.irq_en   = c_item_r.write_data[0];
              LATCH_PALETTE:    latch_nxt.pal_sel  = c_item_r.write_data[0];
              LATCH_FLIP:       latch_nxt.flip     = c_item_r.write_data[0];
              LATCH_COLORTABLE: latch_nxt.ctab_sel = c_item_r.write_data[0];
              LATCH_GFX:        latch_nxt.gfx_sel  = c_item_r.write_data[0];
              default: ;
            endcase
          end
        end
        OP_TICK: begin
          irq_nxt = latch_r.irq_en;
          if (coin_cnt_r != 2'd0) begin
            coin_cnt_nxt = coin_cnt_r - 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r      <= '0;
      coin_cnt_r   <= '0;
      coin_held_r  <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      latch_r      <= latch_nxt;
      coin_cnt_r   <= coin_cnt_nxt;
      coin_held_r  <= coin_held_nxt;
      out_strobe_r <= c_valid_r;
    end
  end

  // Latch outputs report the values after the item has been applied.
  always_ff @(posedge clk) begin
    if (c_valid_r) begin
      out_item_r.read_data           <= rd_nxt;
      out_item_r.irq_request         <= irq_nxt;
      out_item_r.flip_screen         <= latch_nxt.flip;
      out_item_r.palette_bank_out    <= latch_nxt.pal_sel;
      out_item_r.colortable_bank_out <= latch_nxt.ctab_sel;
      out_item_r.gfx_bank_out        <= latch_nxt.gfx_sel;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule
